@@ rtl/rbb_pkg.sv @@
package rbb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WEFF_W     = COL_W + 1;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;

    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int ROW_W      = FH_W + 1;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;

    localparam int COLSUM_W    = 10;
    localparam int SUM_W       = 12;
    localparam int DIV_W       = 4;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic take;
        logic store;
        logic col;
        logic add;
        logic mul;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic item_ok;
        logic emit;
        logic out_free;
    } status_t;

    // Zero acts as one, oversize clamps to the line store depth.
    function automatic logic [WEFF_W-1:0] eff_width(input logic [FW_W-1:0] fw);
        logic [WEFF_W-1:0] w;
        if (fw == '0)
            w = WEFF_W'(1);
        else if (int'(fw) > MAX_WIDTH)
            w = WEFF_W'(MAX_WIDTH);
        else
            w = WEFF_W'(fw);
        return w;
    endfunction

    // ceil(2^19 / d); exact truncated quotient for sums up to 9 * 255.
    function automatic logic [RECIP_W-1:0] div_recip(input logic [DIV_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/rgb_box_blur_3x3.sv @@
// Channel   Dir   Payload
// s_*       in    tdata: in_red, in_green, in_blue; tuser: drain
// m_*       out   tdata: out_red, out_green, out_blue; tlast: frame_last
// cfg_*     in    index 0 frame_width, index 1 frame_height
//
// A beat with no result passes the line store read and write steps; a beat
// that yields a result also passes the column sum, add, reciprocal
// multiply and output load steps of the sequencer. A beat out of frame phase
// (drain inside the frame, pixel while flushing) is consumed and dropped.
// Reset clears counters and control; line stores need no clearing pass.
// A stalled output holds one result while the next beat is already taken.
module rgb_box_blur_3x3 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rbb_pkg::PIX_W-1:0]      s_tdata,   // in_red, in_green, in_blue
    input  logic                           s_tuser,   // drain
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rbb_pkg::PIX_W-1:0]      m_tdata,   // out_red, out_green, out_blue
    output logic                           m_tlast    // frame_last
);
    import rbb_pkg::*;

    cmd_t    cmd;
    status_t status;

    rbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rbb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/rbb_ctrl.sv @@
module rbb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rbb_pkg::status_t status,
    output rbb_pkg::cmd_t    cmd
);
    import rbb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STORE = 3'd1;
    localparam logic [2:0] ST_COL   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // drop beats that do not fit the frame phase
                if (s_tvalid && status.item_ok)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = status.emit ? ST_COL : ST_IDLE;
            end
            ST_COL:
            begin
                cmd.col    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output slot frees up
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/rbb_datapath.sv @@
module rbb_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic [rbb_pkg::PIX_W-1:0]                s_tdata,
    input  logic                                     s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [rbb_pkg::PIX_W-1:0]                m_tdata,
    output logic                                     m_tlast,
    input  rbb_pkg::cmd_t                            cmd,
    output rbb_pkg::status_t                         status
);
    import rbb_pkg::*;

    logic [FW_W-1:0]     frame_width_reg;
    logic [FH_W-1:0]     frame_height_reg;
    logic [WEFF_W-1:0]   w_eff;
    logic [FH_W-1:0]     h_eff;

    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [FH_W-1:0]     out_row_reg, out_row_next;

    logic [PIX_W-1:0]    mem_upper  [MAX_WIDTH];
    logic [PIX_W-1:0]    mem_middle [MAX_WIDTH];
    logic [PIX_W-1:0]    top_rd_reg;
    logic [PIX_W-1:0]    mid_rd_reg;
    logic [PIX_W-1:0]    bot_reg;
    logic [COL_W-1:0]    addr_reg;
    logic                emit_reg;

    logic [PIX_W-1:0]    win_reg [9];

    logic [COLSUM_W-1:0] col_sum_reg [3][NUM_CH];
    logic [COLSUM_W-1:0] col_sum     [3][NUM_CH];
    logic [DIV_W-1:0]    div_reg;
    logic                last_reg;
    logic [SUM_W-1:0]    total_reg   [NUM_CH];
    logic [RECIP_W-1:0]  recip_reg;
    logic [PROD_W-1:0]   prod_reg    [NUM_CH];

    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_data_reg;
    logic                out_last_reg;

    logic                flushing;
    logic                emit_now;
    logic [WEFF_W-1:0]   in_col_inc;
    logic [WEFF_W-1:0]   out_col_inc;
    logic [ROW_W-1:0]    out_row_inc;
    logic                row_top_ok;
    logic                row_bot_ok;
    logic                col_left_ok;
    logic                col_right_ok;
    logic [2:0]          col_ok;
    logic [1:0]          nrows;
    logic [1:0]          ncols;

    assign w_eff = eff_width(frame_width_reg);
    assign h_eff = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;

    assign flushing = (in_row_reg >= {1'b0, h_eff});
    assign emit_now = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

    assign in_col_inc  = {1'b0, in_col_reg} + WEFF_W'(1);
    assign out_col_inc = {1'b0, out_col_reg} + WEFF_W'(1);
    assign out_row_inc = {1'b0, out_row_reg} + ROW_W'(1);

    assign row_top_ok   = (out_row_reg != '0);
    assign row_bot_ok   = (out_row_inc < {1'b0, h_eff});
    assign col_left_ok  = (out_col_reg != '0);
    assign col_right_ok = (out_col_inc < w_eff);
    assign col_ok       = {col_right_ok, 1'b1, col_left_ok};
    assign nrows        = 2'd1 + 2'(row_top_ok) + 2'(row_bot_ok);
    assign ncols        = 2'd1 + 2'(col_left_ok) + 2'(col_right_ok);

    assign status.item_ok  = (flushing == s_tuser);
    assign status.emit     = emit_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (cmd.take)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
        end
        else if (cmd.load)
        begin
            if (last_reg)
            begin
                // frame done: restart every position
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (!col_right_ok)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + FH_W'(1);
            end
            else
            begin
                out_col_next = out_col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // line stores: read at accept, write back in the cycle after
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            top_rd_reg <= mem_upper[in_col_reg];
            mid_rd_reg <= mem_middle[in_col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem_upper[addr_reg]  <= mid_rd_reg;
            mem_middle[addr_reg] <= bot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_reg <= 1'b0;
        else if (cmd.take)
            emit_reg <= emit_now;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            bot_reg  <= flushing ? '0 : s_tdata;
            addr_reg <= in_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (cmd.store)
        begin
            for (int k = 0; k < 6; k++)
                win_reg[k] <= win_reg[k+3];
            win_reg[6] <= top_rd_reg;
            win_reg[7] <= mid_rd_reg;
            win_reg[8] <= bot_reg;
        end
    end

    // per-column sums with out-of-frame taps masked off
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                col_sum[c][ch] =
                      (row_top_ok ? COLSUM_W'(win_reg[c*3][ch*CH_W +: CH_W]) : '0)
                    + COLSUM_W'(win_reg[c*3+1][ch*CH_W +: CH_W])
                    + (row_bot_ok ? COLSUM_W'(win_reg[c*3+2][ch*CH_W +: CH_W]) : '0);
                if (!col_ok[c])
                    col_sum[c][ch] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.col)
        begin
            col_sum_reg <= col_sum;
            div_reg     <= DIV_W'(nrows) * DIV_W'(ncols);
            last_reg    <= !row_bot_ok && !col_right_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
                total_reg[ch] <= SUM_W'(col_sum_reg[0][ch]) + SUM_W'(col_sum_reg[1][ch])
                               + SUM_W'(col_sum_reg[2][ch]);
            recip_reg <= div_recip(div_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
                prod_reg[ch] <= PROD_W'(total_reg[ch]) * PROD_W'(recip_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
                out_data_reg[ch*CH_W +: CH_W] <= prod_reg[ch][RECIP_SHIFT +: CH_W];
            out_last_reg <= last_reg;
        end
    end

endmodule
